// File: hdl/qdac_pkg.sv
// Shared types and constants for the quad DAC register model.
package qdac_pkg;

    // Channel count and read-back frame length
    localparam int CHANNELS   = 4;
    localparam int READ_BYTES = 24;

    // Field widths
    localparam int CODE_W = 12;
    localparam int MV_W   = 13;

    // Internal reference in millivolts, full scale is 2^FS_SHIFT codes
    localparam logic [MV_W-1:0] VREF_INT_MV = 13'd2048;
    localparam int              FS_SHIFT    = 12;

    // Configuration register indexes and reset values
    localparam logic CFG_VDD_MV   = 1'b0;
    localparam logic CFG_DEV_ADDR = 1'b1;
    localparam logic [MV_W-1:0] VDD_RESET_MV  = 13'd5000;
    localparam logic [2:0]      DEV_ADDR_RESET = 3'd0;

    // One bus byte from the I2C front end
    typedef struct packed {
        logic       op;
        logic       first;
        logic       general_call;
        logic [7:0] data_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic [7:0]      read_data;
        logic            ack;
        logic [MV_W-1:0] vout_ch0;
        logic [MV_W-1:0] vout_ch1;
        logic [MV_W-1:0] vout_ch2;
        logic [MV_W-1:0] vout_ch3;
    } result_t;

    // Channel settings; {high byte, low byte} as seen on the bus
    typedef struct packed {
        logic              vref;
        logic [1:0]        pd;
        logic              gain;
        logic [CODE_W-1:0] code;
    } chan_t;

    typedef chan_t [CHANNELS-1:0] chan_arr_t;

    localparam chan_t CHAN_RESET = '{vref: 1'b1, pd: 2'd0, gain: 1'b0, code: '0};

endpackage

// File: hdl/qdac_vout.sv
// Output voltage of one channel in millivolts, clamped to the supply.
module qdac_vout (
    input  qdac_pkg::chan_t                  chan,
    input  logic [qdac_pkg::MV_W-1:0]        vdd_mv,
    output logic [qdac_pkg::MV_W-1:0]        vout_mv
);
    import qdac_pkg::*;

    logic [MV_W-1:0]           vref_mv;
    logic [MV_W+CODE_W-1:0]    prod;
    logic [MV_W+CODE_W:0]      scaled;
    logic [MV_W+CODE_W-FS_SHIFT:0] mv;

    // vref * code, doubled for gain 2, then divided by full scale
    always_comb begin
        vref_mv = chan.vref ? VREF_INT_MV : vdd_mv;
        prod    = (MV_W+CODE_W)'(vref_mv) * (MV_W+CODE_W)'(chan.code);
        scaled  = chan.gain ? {prod, 1'b0} : {1'b0, prod};
        mv      = scaled[MV_W+CODE_W:FS_SHIFT];
    end

    // clamp to the supply rail
    assign vout_mv = (mv > {1'b0, vdd_mv}) ? vdd_mv : mv[MV_W-1:0];

endmodule

// File: hdl/qdac_core.sv
// Command decoder, channel registers, EEPROM copy and read-back for the quad DAC.
module qdac_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  qdac_pkg::item_t        item,
    input  logic [2:0]             dev_addr,
    output logic [7:0]             rd_byte,
    output logic                   ack,
    output qdac_pkg::chan_arr_t    inp_next
);
    import qdac_pkg::*;

    typedef enum logic [4:0] {
        KIND_NONE   = 5'b00001,
        KIND_FAST   = 5'b00010,
        KIND_SINGLE = 5'b00100,
        KIND_SEQ    = 5'b01000,
        KIND_PD     = 5'b10000
    } kind_t;

    // Command patterns
    localparam logic [7:0] FAST_MASK  = 8'hC0;
    localparam logic [7:0] FAST_VAL   = 8'h00;
    localparam logic [7:0] WR_MASK    = 8'hF8;
    localparam logic [7:0] SINGLE_VAL = 8'h58;
    localparam logic [7:0] SEQ_VAL    = 8'h50;
    localparam logic [7:0] GRP_MASK   = 8'hE0;
    localparam logic [7:0] VREF_VAL   = 8'h80;
    localparam logic [7:0] GAIN_VAL   = 8'hC0;
    localparam logic [7:0] PD_VAL     = 8'hA0;
    localparam logic [7:0] GC_RESET   = 8'h06;
    localparam logic [7:0] GC_WAKE    = 8'h09;
    localparam logic [7:0] GC_UPDATE  = 8'h08;

    localparam int PTR_W = $clog2(READ_BYTES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(READ_BYTES - 1);

    chan_arr_t        inp_reg, eep_reg, eep_next;
    kind_t            kind_reg, kind_next;
    logic [2:0]       idx_reg, idx_next;
    logic [7:0]       held_reg, held_next;
    logic [1:0]       tgt_reg, tgt_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;

    logic [7:0]       b;
    logic [PTR_W-1:0] ptr_use, rd_base, rd_rem;
    logic [1:0]       rd_ch, rd_k, fast_ch;
    logic [2:0]       rd_r;
    logic             rd_eep;
    chan_t            rd_chan;

    assign b = item.data_byte;

    // read-back byte at the current pointer
    always_comb begin
        ptr_use = item.first ? '0 : ptr_reg;
        if (ptr_use >= PTR_W'(18)) begin
            rd_ch = 2'd3;
            rd_base = PTR_W'(18);
        end else if (ptr_use >= PTR_W'(12)) begin
            rd_ch = 2'd2;
            rd_base = PTR_W'(12);
        end else if (ptr_use >= PTR_W'(6)) begin
            rd_ch = 2'd1;
            rd_base = PTR_W'(6);
        end else begin
            rd_ch = 2'd0;
            rd_base = '0;
        end
        rd_rem  = ptr_use - rd_base;
        rd_r    = rd_rem[2:0];
        rd_eep  = (rd_r >= 3'd3);
        rd_k    = rd_eep ? 2'(rd_r - 3'd3) : rd_r[1:0];
        rd_chan = rd_eep ? eep_reg[rd_ch] : inp_reg[rd_ch];
        case (rd_k)
            2'd0:    rd_byte = {2'b11, rd_ch, rd_eep, dev_addr};
            2'd1:    rd_byte = rd_chan[15:8];
            default: rd_byte = rd_chan[7:0];
        endcase
    end

    assign fast_ch = idx_reg[2:1];

    // next state for the item
    always_comb begin
        inp_next  = inp_reg;
        eep_next  = eep_reg;
        kind_next = kind_reg;
        idx_next  = idx_reg;
        held_next = held_reg;
        tgt_next  = tgt_reg;
        ptr_next  = ptr_reg;
        ack       = 1'b0;

        if (item.op) begin
            // read ends any write command
            kind_next = KIND_NONE;
            idx_next  = '0;
            if (!item.general_call) begin
                ack      = 1'b1;
                ptr_next = (ptr_use == PTR_LAST) ? '0 : ptr_use + 1'b1;
            end
        end else if (item.general_call) begin
            if (item.first) begin
                kind_next = KIND_NONE;
                idx_next  = '0;
                unique case (b)
                    GC_RESET: begin
                        inp_next = eep_reg;
                        ack      = 1'b1;
                    end
                    GC_WAKE: begin
                        for (int i = 0; i < CHANNELS; i++) inp_next[i].pd = 2'd0;
                        ack = 1'b1;
                    end
                    GC_UPDATE: ack = 1'b1;
                    default:   ack = 1'b0;
                endcase
            end
        end else if (item.first) begin
            // command byte
            kind_next = KIND_NONE;
            idx_next  = '0;
            ack       = 1'b1;
            if ((b & FAST_MASK) == FAST_VAL) begin
                held_next = b;
                tgt_next  = 2'd0;
                idx_next  = 3'd1;
                kind_next = KIND_FAST;
            end else if ((b & WR_MASK) == SINGLE_VAL || (b & WR_MASK) == SEQ_VAL) begin
                tgt_next  = b[2:1];
                idx_next  = 3'd1;
                kind_next = ((b & WR_MASK) == SINGLE_VAL) ? KIND_SINGLE : KIND_SEQ;
            end else if ((b & GRP_MASK) == VREF_VAL) begin
                for (int i = 0; i < CHANNELS; i++) inp_next[i].vref = b[3-i];
            end else if ((b & GRP_MASK) == GAIN_VAL) begin
                for (int i = 0; i < CHANNELS; i++) inp_next[i].gain = b[3-i];
            end else if ((b & GRP_MASK) == PD_VAL) begin
                held_next = b;
                idx_next  = 3'd1;
                kind_next = KIND_PD;
            end else begin
                ack = 1'b0;
            end
        end else begin
            // data byte of the active command
            ack = 1'b1;
            unique case (kind_reg)
                KIND_FAST: begin
                    if (!idx_reg[0]) begin
                        held_next = b;
                    end else begin
                        inp_next[fast_ch].code = {held_reg[3:0], b};
                        inp_next[fast_ch].pd   = held_reg[5:4];
                    end
                    idx_next = idx_reg + 1'b1;
                end
                KIND_SINGLE, KIND_SEQ: begin
                    if (idx_reg[0]) begin
                        held_next = b;
                        idx_next  = 3'd2;
                    end else begin
                        inp_next[tgt_reg] = {held_reg, b};
                        eep_next[tgt_reg] = {held_reg, b};
                        idx_next = 3'd1;
                        if (kind_reg == KIND_SINGLE || tgt_reg == 2'd3) begin
                            kind_next = KIND_NONE;
                            idx_next  = '0;
                        end else begin
                            tgt_next = tgt_reg + 1'b1;
                        end
                    end
                end
                KIND_PD: begin
                    inp_next[0].pd = held_reg[3:2];
                    inp_next[1].pd = held_reg[1:0];
                    inp_next[2].pd = b[7:6];
                    inp_next[3].pd = b[5:4];
                    kind_next = KIND_NONE;
                    idx_next  = '0;
                end
                default: ack = 1'b0;
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                inp_reg[i] <= CHAN_RESET;
                eep_reg[i] <= CHAN_RESET;
            end
            kind_reg <= KIND_NONE;
            idx_reg  <= '0;
            held_reg <= '0;
            tgt_reg  <= '0;
            ptr_reg  <= '0;
        end else if (step) begin
            inp_reg  <= inp_next;
            eep_reg  <= eep_next;
            kind_reg <= kind_next;
            idx_reg  <= idx_next;
            held_reg <= held_next;
            tgt_reg  <= tgt_next;
            ptr_reg  <= ptr_next;
        end
    end

endmodule

// File: hdl/quad_dac_i2c_register_model.sv
// Top level of the quad 12-bit DAC register model: item pipeline, configuration, output stage.
// One bus byte per item; a new item is taken every cycle while the result register is free or
// being drained. Its result passes through the input register, then the result register, and
// holds there until taken. The command decode, register update and four 13x12-bit millivolt
// products sit in the single combinational stage between those two registers. Reset leaves
// vdd_mv at 5000 mV. vdd_mv (index 0) and device_address (index 1) are written through the
// cfg_ port; the user must write them only while the block is idle; this is not enforced.
module quad_dac_i2c_register_model (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  qdac_pkg::item_t             s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output qdac_pkg::result_t           m_item,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [qdac_pkg::MV_W-1:0]   cfg_wdata
);
    import qdac_pkg::*;

    logic            in_valid_reg, out_valid_reg, advance;
    item_t           item_reg;
    result_t         res_reg, res_next;
    logic [MV_W-1:0] vdd_reg;
    logic [2:0]      addr_reg;
    logic [7:0]      rd_byte;
    logic            ack;
    chan_arr_t       inp_next;
    logic [MV_W-1:0] vout [CHANNELS];

    // handshake: move on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = res_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vdd_reg  <= VDD_RESET_MV;
            addr_reg <= DEV_ADDR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_VDD_MV:   vdd_reg  <= cfg_wdata;
                CFG_DEV_ADDR: addr_reg <= cfg_wdata[2:0];
                default:      vdd_reg  <= vdd_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    qdac_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .item     (item_reg),
        .dev_addr (addr_reg),
        .rd_byte  (rd_byte),
        .ack      (ack),
        .inp_next (inp_next)
    );

    // per-channel millivolts from the updated settings
    for (genvar c = 0; c < CHANNELS; c++) begin : g_vout
        qdac_vout u_vout (
            .chan    (inp_next[c]),
            .vdd_mv  (vdd_reg),
            .vout_mv (vout[c])
        );
    end

    always_comb begin
        res_next.read_data = (item_reg.op && ack) ? rd_byte : 8'd0;
        res_next.ack       = ack;
        res_next.vout_ch0  = vout[0];
        res_next.vout_ch1  = vout[1];
        res_next.vout_ch2  = vout[2];
        res_next.vout_ch3  = vout[3];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // a refused byte never returns data
    a_nack_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.ack |-> m_item.read_data == 8'd0)
        else $error("refused item carries read data");

    // outputs stay under the supply clamp
    a_vout_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.vout_ch0 <= vdd_reg && m_item.vout_ch1 <= vdd_reg &&
                    m_item.vout_ch2 <= vdd_reg && m_item.vout_ch3 <= vdd_reg)
        else $error("output above supply");

    // an item that advances always shows up in the result register
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced item lost");

    // a stalled result is held
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule
